>>> design/issw_pkg.sv
// shared types and constants of the iret single-step watch
// no dependencies
package issw_pkg;

    localparam int unsigned ATTEMPT_W    = 7;
    localparam int unsigned DEF_MAX_ATTEMPTS = 64;
    localparam int unsigned CFG_INDEX_W  = 8;

    localparam logic [63:0] FLAG_TF          = 64'h0000_0000_0000_0100;
    localparam logic [63:0] DR6_BS           = 64'h0000_0000_0000_4000;
    localparam logic [63:0] DR6_OTHER_CAUSES = 64'h0000_0000_0000_a00f;
    localparam logic [63:0] EXIT_DB          = 64'h0000_0000_0000_0041;
    localparam logic [31:0] ASYNC_INTERCEPTS = 32'h0000_001f;
    localparam logic [31:0] IRET_INTERCEPT   = 32'h0010_0000;

    localparam int unsigned TF_BIT = 8;
    localparam int unsigned BS_BIT = 14;

    localparam logic [63:0] RST_INVALID_CODE = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] RST_NPF_CODE     = 64'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_CODE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NPF_CODE     = 8'd1;

    // tdata / tuser widths
    localparam int unsigned IN_TDATA_W  = 328;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 200;
    localparam int unsigned OUT_TUSER_W = 4;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_ARM     = 2'd1,
        OP_OBSERVE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_REFUSED  = 3'd0,
        ST_OK       = 3'd1,
        ST_FAULT    = 3'd2,
        ST_MONITOR  = 3'd3,
        ST_RETIRED  = 3'd4,
        ST_CONTINUE = 3'd5
    } t_status;

    typedef struct packed {
        t_op         op;
        logic        event_pending;
        logic        intinfo_valid;
        logic [63:0] exit_code;
        logic [63:0] guest_rip;
        logic [63:0] guest_rflags;
        logic [63:0] guest_dr6;
        logic [31:0] misc_intercepts;
        logic [31:0] exception_intercepts;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic        write_back;
        logic [63:0] rflags_out;
        logic [63:0] dr6_out;
        logic [31:0] misc_out;
        logic [31:0] except_out;
        logic        completed;
    } t_result;

    // control state, cleared by reset
    typedef struct packed {
        logic                 requested;
        logic                 applied;
        logic [ATTEMPT_W-1:0] attempts;
        logic [63:0]          entries;
    } t_ctrl;

    // guest values captured at arm time
    typedef struct packed {
        logic [63:0] rip;
        logic [63:0] rflags;
        logic [63:0] dr6;
        logic [31:0] misc;
        logic [31:0] except;
    } t_saved;

endpackage

>>> design/issw_in_reg.sv
// input beat register of the iret single-step watch
// depends on issw_pkg
module issw_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  issw_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output issw_pkg::t_item o_item
);
    import issw_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> design/issw_eval.sv
// per-beat evaluation: decides the result and the next watch state
// depends on issw_pkg
module issw_eval #(
    parameter int unsigned MAX_ATTEMPTS = issw_pkg::DEF_MAX_ATTEMPTS
) (
    input  issw_pkg::t_item   i_item,
    input  issw_pkg::t_ctrl   i_ctrl,
    input  issw_pkg::t_saved  i_saved,
    input  logic [63:0]       i_invalid_code,
    input  logic [63:0]       i_npf_code,
    output issw_pkg::t_result o_result,
    output issw_pkg::t_ctrl   o_ctrl,
    output logic              o_save
);
    import issw_pkg::*;

    logic        bs_now;
    logic        is_db;
    logic        retired;
    logic        monitor;
    logic [63:0] nfl;
    logic [63:0] nd6;
    logic        arm_ok;

    assign bs_now  = i_item.guest_dr6[BS_BIT];
    assign is_db   = (i_item.exit_code == EXIT_DB);
    assign retired = (i_item.guest_rip != i_saved.rip) || (is_db && bs_now);
    assign monitor = retired && is_db && bs_now && !i_saved.rflags[TF_BIT]
                     && ((i_item.guest_dr6 & DR6_OTHER_CAUSES) == 64'd0);

    // tf goes back to the saved value unless the instruction retired
    assign nfl = retired ? i_item.guest_rflags
                         : ((i_item.guest_rflags & ~FLAG_TF) | (i_saved.rflags & FLAG_TF));
    assign nd6 = (i_item.guest_dr6 & ~DR6_BS) | (i_saved.dr6 & DR6_BS)
                 | (i_saved.rflags[TF_BIT] ? (i_item.guest_dr6 & DR6_BS) : 64'd0);

    assign arm_ok = i_ctrl.requested && !i_ctrl.applied
                    && (i_ctrl.attempts < ATTEMPT_W'(MAX_ATTEMPTS))
                    && (i_ctrl.entries != '1) && !i_item.event_pending;

    always_comb begin
        o_result = '0;
        o_result.status = ST_REFUSED;
        o_ctrl   = i_ctrl;
        o_save   = 1'b0;
        case (i_item.op)
            OP_REQUEST: begin
                if (!(i_ctrl.requested || i_ctrl.applied)) begin
                    o_ctrl.requested = 1'b1;
                    o_ctrl.attempts  = '0;
                    o_result.status  = ST_OK;
                end
            end
            OP_ARM: begin
                if (arm_ok) begin
                    o_save              = 1'b1;
                    o_ctrl.attempts     = i_ctrl.attempts + ATTEMPT_W'(1);
                    o_ctrl.entries      = i_ctrl.entries + 64'd1;
                    o_ctrl.applied      = 1'b1;
                    o_result.status     = ST_OK;
                    o_result.write_back = 1'b1;
                    o_result.rflags_out = i_item.guest_rflags | FLAG_TF;
                    o_result.dr6_out    = i_item.guest_dr6 & ~DR6_BS;
                    o_result.misc_out   = (i_item.misc_intercepts | ASYNC_INTERCEPTS)
                                          & ~IRET_INTERCEPT;
                    o_result.except_out = '1;
                end
            end
            OP_OBSERVE: begin
                if (!(i_ctrl.requested && i_ctrl.applied)
                    || (i_item.exit_code == i_invalid_code) || i_item.intinfo_valid) begin
                    o_result.status = ST_FAULT;
                end else begin
                    o_ctrl.applied      = 1'b0;
                    o_ctrl.requested    = !retired && (i_item.exit_code == i_npf_code);
                    o_result.status     = monitor ? ST_MONITOR
                                                  : (retired ? ST_RETIRED : ST_CONTINUE);
                    o_result.write_back = 1'b1;
                    o_result.rflags_out = nfl;
                    o_result.dr6_out    = nd6;
                    o_result.misc_out   = i_saved.misc;
                    o_result.except_out = i_saved.except;
                    o_result.completed  = retired;
                end
            end
            default: begin
                o_result.status = ST_REFUSED;
            end
        endcase
    end

endmodule

>>> design/iret_single_step_watch.sv
// iret single-step watch: request, arm and observe beats over one intercepted iret
// throughput: one beat per cycle while result beats are not stalled; beats pass the
// input register, then evaluation, then result register
// reset (synchronous, active low) closes any watch, clears attempt and entry counts,
// and sets invalid_exit_code to all ones and npf_exit_code to 1024
// depends on issw_pkg, issw_in_reg, issw_eval
module iret_single_step_watch #(
    parameter int unsigned MAX_ATTEMPTS = issw_pkg::DEF_MAX_ATTEMPTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beats
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [0] event_pending, [1] intinfo_valid, [65:2] exit_code, [129:66] guest_rip,
    // [193:130] guest_rflags, [257:194] guest_dr6, [289:258] misc_intercepts,
    // [321:290] exception_intercepts, rest zero
    input  logic [issw_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] op
    input  logic [issw_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result beats
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [63:0] rflags_out, [127:64] dr6_out, [159:128] misc_out, [191:160] except_out,
    // [192] completed, rest zero
    output logic [issw_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] status, [3] write_back
    output logic [issw_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [issw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]                      i_cfg_data
);
    import issw_pkg::*;

    t_item   in_item;
    t_item   cur_item;
    logic    cur_valid;
    logic    advance;
    t_result eval_result;
    t_ctrl   n_ctrl;
    logic    eval_save;

    logic        r_out_valid;
    t_result     r_result;
    t_ctrl       r_ctrl;
    t_saved      r_saved;
    logic [63:0] r_invalid_code;
    logic [63:0] r_npf_code;

    // unpack the input beat
    assign in_item.op                   = t_op'(i_s_axis_tuser[1:0]);
    assign in_item.event_pending        = i_s_axis_tdata[0];
    assign in_item.intinfo_valid        = i_s_axis_tdata[1];
    assign in_item.exit_code            = i_s_axis_tdata[65:2];
    assign in_item.guest_rip            = i_s_axis_tdata[129:66];
    assign in_item.guest_rflags         = i_s_axis_tdata[193:130];
    assign in_item.guest_dr6            = i_s_axis_tdata[257:194];
    assign in_item.misc_intercepts      = i_s_axis_tdata[289:258];
    assign in_item.exception_intercepts = i_s_axis_tdata[321:290];

    // the held beat moves on when the result register is free or draining
    assign advance = cur_valid && (!r_out_valid || i_m_axis_tready);

    issw_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .i_take  (advance),
        .o_valid (cur_valid),
        .o_item  (cur_item)
    );

    // state is read and updated in the same cycle, so beats follow back to back
    issw_eval #(
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_eval (
        .i_item         (cur_item),
        .i_ctrl         (r_ctrl),
        .i_saved        (r_saved),
        .i_invalid_code (r_invalid_code),
        .i_npf_code     (r_npf_code),
        .o_result       (eval_result),
        .o_ctrl         (n_ctrl),
        .o_save         (eval_save)
    );

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_ctrl         <= '0;
            r_invalid_code <= RST_INVALID_CODE;
            r_npf_code     <= RST_NPF_CODE;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctrl      <= n_ctrl;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && i_cfg_index == CFG_INVALID_CODE) begin
                r_invalid_code <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_NPF_CODE) begin
                r_npf_code <= i_cfg_data;
            end
        end
        // payload registers
        if (advance) begin
            r_result <= eval_result;
        end
        if (advance && eval_save) begin
            r_saved.rip    <= cur_item.guest_rip;
            r_saved.rflags <= cur_item.guest_rflags;
            r_saved.dr6    <= cur_item.guest_dr6;
            r_saved.misc   <= cur_item.misc_intercepts;
            r_saved.except <= cur_item.exception_intercepts;
        end
    end

    // pack the result beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_result.write_back, r_result.status};
    assign o_m_axis_tdata  = {7'd0, r_result.completed, r_result.except_out,
                              r_result.misc_out, r_result.dr6_out, r_result.rflags_out};

endmodule
